// ----- sv/train_speed_pi_controller_top_assert.svh -----
// ----------------------------------------------------------------------------
// train speed pi controller assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef TRAIN_SPEED_PI_CONTROLLER_TOP_ASSERT_SVH
`define TRAIN_SPEED_PI_CONTROLLER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TSPC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tspc assertion failed");

// condition holds at every edge out of reset
`define TSPC_ASSERT_ALW(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tspc assertion failed");

`endif

// ----- sv/tspc_pkg.sv -----
// ----------------------------------------------------------------------------
// tspc_pkg
// widths, register map, reset values and shared types of the speed controller
// ----------------------------------------------------------------------------
package tspc_pkg;

  localparam int SPEED_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int DWELL_W  = 16;
  localparam int MAXP_W   = 17;
  localparam int POWER_W  = 18;
  localparam int E_W      = 18;
  localparam int INTEG_W  = 40;
  localparam int MUL_AW   = 17;
  localparam int MUL_BW   = 40;
  localparam int MUL_PW   = 57;
  localparam int ACC_W    = 58;
  localparam int RND_SH   = 32;
  localparam int PFULL_W  = ACC_W - RND_SH;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_HALF_PERIOD = 3'd2;
  localparam logic [2:0] REG_AUTO_MODE   = 3'd3;
  localparam logic [2:0] REG_DWELL_TICKS = 3'd4;
  localparam logic [2:0] REG_MAX_POWER   = 3'd5;

  localparam logic [GAIN_W-1:0]  RST_HALF_PERIOD = 16'd32768;
  localparam logic [DWELL_W-1:0] RST_DWELL_TICKS = 16'd60;
  localparam logic [MAXP_W-1:0]  RST_MAX_POWER   = 17'd120000;

  localparam logic signed [INTEG_W:0] INTEG_MAX = 41'sd549755813887;
  localparam logic signed [INTEG_W:0] INTEG_MIN = -41'sd549755813887;

  typedef struct packed {
    logic held;
    logic force_zero;
    logic brake_cmd;
    logic doors_open;
    logic headlights;
  } stop_status_t;

endpackage

// ----- sv/train_speed_pi_controller_top.sv -----
// ----------------------------------------------------------------------------
// train_speed_pi_controller_top
// trapezoidal pi speed controller with saturated power and station stops
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   speed, brakes, limit, setpoint, ...
//  out_     output     out_valid / out_stall power, service brake, doors, lights
//  cfg      apb        psel/penable/pwrite   six control registers
//
//  an item runs from acceptance through the states idle, mul_a, mul_b, mul_c, done:
//  three products in the mul states on the one shared 17x40 multiplier, then the
//  result; the third product needs the first and all share one multiplier, so one item is worked at a time
//  reset (rst_n low, synchronous) clears integrator and stop sequencer and
//  returns the control registers to their defaults
//  a stalled result holds the last cycle; the next item waits in the caller
// ----------------------------------------------------------------------------
module train_speed_pi_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tspc_pkg::SPEED_W-1:0]        in_current_speed,
  input  logic                                in_emergency_brake,
  input  logic                                in_driver_brake,
  input  logic [tspc_pkg::BYTE_W-1:0]         in_speed_limit,
  input  logic [tspc_pkg::BYTE_W-1:0]         in_track_setpoint,
  input  logic [tspc_pkg::BYTE_W-1:0]         in_authority,
  input  logic [tspc_pkg::BYTE_W-1:0]         in_driver_speed,
  input  logic [tspc_pkg::BYTE_W-1:0]         in_beacon_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tspc_pkg::POWER_W-1:0] out_power,
  output logic                                out_service_brake,
  output logic                                out_doors_open,
  output logic                                out_headlights,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tspc_pkg::ADDR_W-1:0]         paddr,
  input  logic [tspc_pkg::DATA_W-1:0]         pwdata,
  output logic [tspc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_MUL_B = 3'd2;
  localparam logic [2:0] ST_MUL_C = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // control registers
  logic [tspc_pkg::GAIN_W-1:0]   prop_gain_r, integ_gain_r, half_period_r;
  logic                          auto_mode_r;
  logic [tspc_pkg::DWELL_W-1:0]  dwell_ticks_r;
  logic [tspc_pkg::MAXP_W-1:0]   max_power_r;
  logic                          cfg_wr;
  logic [2:0]                    reg_idx;

  // sequencer and integrator state
  logic [2:0]                          state_r, state_nxt;
  logic signed [tspc_pkg::INTEG_W-1:0] integ_sum_r;
  logic signed [tspc_pkg::E_W-1:0]     prev_error_r;

  // latched item
  logic [tspc_pkg::SPEED_W-1:0] speed_r;
  logic                         ebrake_r, dbrake_r;
  logic [tspc_pkg::BYTE_W-1:0]  limit_r, setp_r, auth_r, drv_r, beacon_r;

  // datapath
  logic [tspc_pkg::BYTE_W-1:0]         target;
  logic signed [tspc_pkg::E_W-1:0]     e_now, e_r, e_sum;
  logic                                mul_en;
  logic [tspc_pkg::MUL_AW-1:0]         mul_a;
  logic signed [tspc_pkg::MUL_BW-1:0]  mul_b;
  logic signed [tspc_pkg::MUL_PW-1:0]  prod_r;
  logic signed [tspc_pkg::INTEG_W:0]   isum_ext;
  logic signed [tspc_pkg::INTEG_W-1:0] isum_sat;
  logic signed [tspc_pkg::ACC_W-1:0]   acc_r, acc_nxt, sum_full;
  logic signed [tspc_pkg::PFULL_W-1:0] p_full, mp_full, p_sat;
  logic signed [tspc_pkg::POWER_W-1:0] power_nxt, mp_s;
  logic                                active, commit;
  tspc_pkg::stop_status_t              st;

  // output register
  logic                                out_valid_r;
  logic signed [tspc_pkg::POWER_W-1:0] out_power_r;
  logic                                out_service_brake_r, out_doors_open_r, out_headlights_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tspc_pkg::REG_PROP_GAIN:   prdata = {16'd0, prop_gain_r};
      tspc_pkg::REG_INTEG_GAIN:  prdata = {16'd0, integ_gain_r};
      tspc_pkg::REG_HALF_PERIOD: prdata = {16'd0, half_period_r};
      tspc_pkg::REG_AUTO_MODE:   prdata = {31'd0, auto_mode_r};
      tspc_pkg::REG_DWELL_TICKS: prdata = {16'd0, dwell_ticks_r};
      tspc_pkg::REG_MAX_POWER:   prdata = {15'd0, max_power_r};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      half_period_r <= tspc_pkg::RST_HALF_PERIOD;
      auto_mode_r   <= 1'b1;
      dwell_ticks_r <= tspc_pkg::RST_DWELL_TICKS;
      max_power_r   <= tspc_pkg::RST_MAX_POWER;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tspc_pkg::REG_PROP_GAIN:   prop_gain_r   <= pwdata[15:0];
        tspc_pkg::REG_INTEG_GAIN:  integ_gain_r  <= pwdata[15:0];
        tspc_pkg::REG_HALF_PERIOD: half_period_r <= pwdata[15:0];
        tspc_pkg::REG_AUTO_MODE:   auto_mode_r   <= pwdata[0];
        tspc_pkg::REG_DWELL_TICKS: dwell_ticks_r <= pwdata[15:0];
        tspc_pkg::REG_MAX_POWER:   max_power_r   <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_stall = (state_r != ST_IDLE);
  assign commit   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_MUL_C;
      ST_MUL_C: state_nxt = ST_DONE;
      ST_DONE:  if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      speed_r  <= in_current_speed;
      ebrake_r <= in_emergency_brake;
      dbrake_r <= in_driver_brake;
      limit_r  <= in_speed_limit;
      setp_r   <= in_track_setpoint;
      auth_r   <= in_authority;
      drv_r    <= in_driver_speed;
      beacon_r <= in_beacon_code;
    end
  end

  // ---------------- error and multiplier operands ----------------
  assign target = (speed_r < {limit_r, 8'd0}) ? (auto_mode_r ? setp_r : drv_r) : limit_r;
  assign e_now  = $signed({2'b00, target, 8'd0}) - $signed({2'b00, speed_r});
  assign e_sum  = e_now + prev_error_r;
  assign active = !(ebrake_r || dbrake_r || (auth_r == '0) || st.held);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      ST_MUL_A: begin
        // half period times trapezoid edge sum
        mul_en = 1'b1;
        mul_a  = {1'b0, half_period_r};
        mul_b  = {{(tspc_pkg::MUL_BW-tspc_pkg::E_W){e_sum[tspc_pkg::E_W-1]}}, e_sum};
      end
      ST_MUL_B: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, prop_gain_r};
        mul_b  = {{(tspc_pkg::MUL_BW-tspc_pkg::E_W){e_r[tspc_pkg::E_W-1]}}, e_r};
      end
      ST_MUL_C: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, integ_gain_r};
        mul_b  = integ_sum_r;
      end
      default: begin
      end
    endcase
  end

  tspc_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // ---------------- integrator ----------------
  assign isum_ext = {integ_sum_r[tspc_pkg::INTEG_W-1], integ_sum_r} +
                    prod_r[tspc_pkg::INTEG_W:0];

  always_comb begin
    if (isum_ext > tspc_pkg::INTEG_MAX) begin
      isum_sat = tspc_pkg::INTEG_MAX[tspc_pkg::INTEG_W-1:0];
    end else if (isum_ext < tspc_pkg::INTEG_MIN) begin
      isum_sat = tspc_pkg::INTEG_MIN[tspc_pkg::INTEG_W-1:0];
    end else begin
      isum_sat = isum_ext[tspc_pkg::INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      integ_sum_r  <= '0;
      prev_error_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL_B && active) begin
        integ_sum_r  <= isum_sat;
        prev_error_r <= e_r;
      end
    end
  end

  // ---------------- output sum, rounding, saturation ----------------
  // proportional term is shifted to q.32 and carries the half-up rounding bias
  assign acc_nxt  = ({prod_r[tspc_pkg::MUL_PW-1], prod_r} <<< 16) +
                    (58'sd1 <<< (tspc_pkg::RND_SH - 1));
  assign sum_full = acc_r + {prod_r[tspc_pkg::MUL_PW-1], prod_r};
  assign p_full   = sum_full[tspc_pkg::ACC_W-1:tspc_pkg::RND_SH];
  assign mp_full  = $signed({{(tspc_pkg::PFULL_W-tspc_pkg::MAXP_W){1'b0}}, max_power_r});
  assign mp_s     = $signed({1'b0, max_power_r});

  always_comb begin
    if (p_full > mp_full) begin
      p_sat = mp_full;
    end else if (p_full < -mp_full) begin
      p_sat = -mp_full;
    end else begin
      p_sat = p_full;
    end
  end

  assign power_nxt = (active && !st.force_zero) ? p_sat[tspc_pkg::POWER_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_A) begin
      e_r <= e_now;
    end
    if (state_r == ST_MUL_C) begin
      acc_r <= acc_nxt;
    end
  end

  tspc_stop u_stop (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (commit),
    .beacon      (beacon_r),
    .speed_zero  (speed_r == '0),
    .dbrake      (dbrake_r),
    .dwell_ticks (dwell_ticks_r),
    .st          (st)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_power_r         <= power_nxt;
      out_service_brake_r <= st.brake_cmd;
      out_doors_open_r    <= st.doors_open;
      out_headlights_r    <= st.headlights;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_power         = out_power_r;
  assign out_service_brake = out_service_brake_r;
  assign out_doors_open    = out_doors_open_r;
  assign out_headlights    = out_headlights_r;

  // ---------------- assertions ----------------
`include "train_speed_pi_controller_top_assert.svh"

  `TSPC_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE)
  `TSPC_ASSERT_IMP(a_integ_only_in_mul_b, !$stable(integ_sum_r), $past(state_r) == ST_MUL_B)
  `TSPC_ASSERT_IMP(a_power_in_range, out_valid_r, (out_power_r <= mp_s) && (out_power_r >= -mp_s))
  `TSPC_ASSERT_IMP(a_doors_need_brake, out_valid_r && out_doors_open_r, out_service_brake_r)

endmodule

// ----- sv/tspc_mul.sv -----
// ----------------------------------------------------------------------------
// tspc_mul
// shared unsigned by signed multiplier with registered product
// ----------------------------------------------------------------------------
module tspc_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic        [tspc_pkg::MUL_AW-1:0]    a,
  input  logic signed [tspc_pkg::MUL_BW-1:0]    b,
  output logic signed [tspc_pkg::MUL_PW-1:0]    prod_r
);

  logic signed [tspc_pkg::MUL_AW+tspc_pkg::MUL_BW:0] full;

  assign full = $signed({1'b0, a}) * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full[tspc_pkg::MUL_PW-1:0];
    end
  end

endmodule

// ----- sv/tspc_stop.sv -----
// ----------------------------------------------------------------------------
// tspc_stop
// beacon decode and station-stop sequencer: brake, doors open, dwell, release
// ----------------------------------------------------------------------------
module tspc_stop (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             commit,
  input  logic [tspc_pkg::BYTE_W-1:0]      beacon,
  input  logic                             speed_zero,
  input  logic                             dbrake,
  input  logic [tspc_pkg::DWELL_W-1:0]     dwell_ticks,
  output tspc_pkg::stop_status_t           st
);

  localparam logic [1:0] PH_RUN   = 2'd0;
  localparam logic [1:0] PH_BRAKE = 2'd1;
  localparam logic [1:0] PH_DWELL = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [7:0] BC_PLAIN      = 8'd1;
  localparam logic [7:0] BC_LIGHTS     = 8'd2;
  localparam logic [7:0] BC_STN        = 8'd3;
  localparam logic [7:0] BC_STN_LIGHTS = 8'd4;

  logic [1:0]                      phase_r, phase_nxt;
  logic [tspc_pkg::DWELL_W-1:0]    count_r, count_nxt;
  logic                            station_r, station_nxt;
  logic                            lights_r, lights_nxt;

  always_comb begin
    station_nxt = station_r;
    lights_nxt  = lights_r;
    unique case (beacon)
      BC_PLAIN: begin
        station_nxt = 1'b0;
        lights_nxt  = 1'b0;
      end
      BC_LIGHTS: begin
        station_nxt = 1'b0;
        lights_nxt  = 1'b1;
      end
      BC_STN: begin
        station_nxt = 1'b1;
        lights_nxt  = 1'b0;
      end
      BC_STN_LIGHTS: begin
        station_nxt = 1'b1;
        lights_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    if (!station_nxt) begin
      phase_nxt = PH_RUN;
    end else begin
      unique case (phase_r)
        PH_RUN: begin
          if (!speed_zero) begin
            phase_nxt = PH_BRAKE;
          end else begin
            phase_nxt = PH_DWELL;
            count_nxt = '0;
          end
        end
        PH_BRAKE: begin
          if (speed_zero) begin
            phase_nxt = PH_DWELL;
            count_nxt = '0;
          end
        end
        PH_DWELL: begin
          if (count_r >= dwell_ticks) begin
            phase_nxt = PH_DONE;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st.held       = (phase_r == PH_BRAKE) || (phase_r == PH_DWELL);
    st.force_zero = station_nxt && (phase_r != PH_DONE);
    st.brake_cmd  = dbrake || (phase_nxt == PH_BRAKE) || (phase_nxt == PH_DWELL);
    st.doors_open = (phase_nxt == PH_DWELL);
    st.headlights = lights_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RUN;
      count_r   <= '0;
      station_r <= 1'b0;
      lights_r  <= 1'b0;
    end else if (commit) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      station_r <= station_nxt;
      lights_r  <= lights_nxt;
    end
  end

endmodule
